// File: sv/wpir_pkg.sv
// ----------------------------------------------------------------------------
// wpir_pkg: shared types and constants
// Payload structs, op codes, register indexes, controller states and the
// command/status bundles for the windowed peak intensity rank block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpir_pkg;

   localparam int WPIR_MAX_PEAKS = 1024;

   localparam int OP_W       = 2;
   localparam int MZ_W       = 32;
   localparam int INT_W      = 32;
   localparam int IDX_W      = 10;
   localparam int RANK_W     = 10;
   localparam int LVL_W      = 6;
   localparam int HW_W       = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
   localparam logic [MZ_W-1:0]   MZ_MAX   = {MZ_W{1'b1}};

   // op codes
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_HALF  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LVL_FLOOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LVL_CEIL  = 2'd2;

   localparam logic [HW_W-1:0]  WIN_HALF_RST  = 24'd500000;
   localparam logic [LVL_W-1:0] LVL_FLOOR_RST = 6'd2;
   localparam logic [LVL_W-1:0] LVL_CEIL_RST  = 6'd10;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [MZ_W-1:0]  mz_value;
      logic [INT_W-1:0] intensity;
      logic [IDX_W-1:0] peak_index;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [RANK_W-1:0] rank;
      logic [LVL_W-1:0]  lowest_level;
      logic              has_level;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OWN,
      ST_LEFT,
      ST_RIGHT,
      ST_DONE
   } state_type;

   // next neighbor pointer source
   typedef enum logic [2:0] {
      NB_HOLD,
      NB_QIDX,
      NB_DEC,
      NB_INC,
      NB_PINC
   } nb_sel_type;

   typedef struct packed {
      nb_sel_type nb_sel;
      logic       clear_count;
      logic       load_peak;
      logic       start_query;
      logic       capture_own;
      logic       count_rank;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic idx_ok;
      logic p_zero;
      logic p_last;
      logic nb_zero;
      logic nb_last;
      logic below_lo;
      logic above_hi;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// File: sv/wpir_ctrl.sv
// ----------------------------------------------------------------------------
// wpir_ctrl: query sequencer
// Accepts ops and, for a query, walks left and right of the queried peak one
// neighbor per cycle until the window edge or the spectrum edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpir_ctrl import wpir_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [OP_W-1:0] req_op,
   output logic                 req_ready,
   input  wire sts_type         sts,
   output cmd_type              cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.nb_sel = NB_HOLD;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_op)
                  OP_CLEAR: cmd.clear_count = 1'b1;
                  OP_LOAD:  cmd.load_peak   = 1'b1;
                  OP_QUERY: begin
                     cmd.start_query = 1'b1;
                     cmd.nb_sel      = NB_QIDX;
                     state_in        = sts.idx_ok ? ST_OWN : ST_DONE;
                  end
                  default: ;
               endcase
            end
         end
         ST_OWN: begin
            cmd.capture_own = 1'b1;
            if (!sts.p_zero) begin
               cmd.nb_sel = NB_DEC;
               state_in   = ST_LEFT;
            end else if (sts.p_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.nb_sel = NB_PINC;
               state_in   = ST_RIGHT;
            end
         end
         ST_LEFT: begin
            cmd.count_rank = !sts.below_lo;
            if (!sts.below_lo && !sts.nb_zero) begin
               cmd.nb_sel = NB_DEC;
            end else if (sts.p_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.nb_sel = NB_PINC;
               state_in   = ST_RIGHT;
            end
         end
         ST_RIGHT: begin
            cmd.count_rank = !sts.above_hi;
            if (sts.above_hi || sts.nb_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.nb_sel = NB_INC;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// File: sv/wpir_dpath.sv
// ----------------------------------------------------------------------------
// wpir_dpath: peak stores, registers and rank datapath
// Holds the m/z and intensity memories, the peak count, the config
// registers, the window bounds, the rank counter and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpir_dpath import wpir_pkg::*; #(
   parameter int MAX_PEAKS = WPIR_MAX_PEAKS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire cmd_type               cmd,
   output sts_type                    sts
);

   localparam int AW = $clog2(MAX_PEAKS);
   localparam int CW = $clog2(MAX_PEAKS + 1);
   localparam int IW = (CW > IDX_W) ? CW : IDX_W;
   localparam logic [CW-1:0] CAP = CW'(MAX_PEAKS);

   logic [MZ_W-1:0]  mz_mem  [MAX_PEAKS];
   logic [INT_W-1:0] int_mem [MAX_PEAKS];

   logic [MZ_W-1:0]   rd_mz_ff;
   logic [INT_W-1:0]  rd_int_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     p_ff;
   logic [AW-1:0]     nb_ff, nb_in;
   logic [INT_W-1:0]  own_ff;
   logic [MZ_W-1:0]   lo_ff, hi_ff;
   logic [RANK_W-1:0] rank_ff;
   logic              err_ff;
   logic [HW_W-1:0]   hw_ff;
   logic [LVL_W-1:0]  min_ff, max_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [IW-1:0]   idx_w;
   logic [AW-1:0]   qidx;
   logic            not_full;
   logic [MZ_W:0]   hi_sum;
   logic [MZ_W-1:0] lo_val, hi_val;
   logic            has;

   assign idx_w    = IW'(req_data.peak_index);
   assign qidx     = idx_w[AW-1:0];
   assign not_full = (count_ff != CAP);

   // pointer of the entry whose data shows up on the read registers
   always_comb begin
      case (cmd.nb_sel)
         NB_QIDX: nb_in = qidx;
         NB_DEC:  nb_in = nb_ff - AW'(1);
         NB_INC:  nb_in = nb_ff + AW'(1);
         NB_PINC: nb_in = p_ff + AW'(1);
         default: nb_in = nb_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_peak && not_full) begin
         mz_mem[count_ff[AW-1:0]]  <= req_data.mz_value;
         int_mem[count_ff[AW-1:0]] <= req_data.intensity;
      end
      rd_mz_ff  <= mz_mem[nb_in];
      rd_int_ff <= int_mem[nb_in];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.load_peak && not_full) begin
         count_in = count_ff + CW'(1);
      end
   end

   // saturating window bounds
   assign lo_val = (rd_mz_ff >= MZ_W'(hw_ff)) ? rd_mz_ff - MZ_W'(hw_ff) : '0;
   assign hi_sum = (MZ_W + 1)'(rd_mz_ff) + (MZ_W + 1)'(hw_ff);
   assign hi_val = hi_sum[MZ_W] ? MZ_MAX : hi_sum[MZ_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hw_ff    <= WIN_HALF_RST;
         min_ff   <= LVL_FLOOR_RST;
         max_ff   <= LVL_CEIL_RST;
      end else begin
         count_ff <= count_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WIN_HALF:  hw_ff  <= csr_wdata[HW_W-1:0];
               CSR_LVL_FLOOR: min_ff <= csr_wdata[LVL_W-1:0];
               CSR_LVL_CEIL:  max_ff <= csr_wdata[LVL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      nb_ff <= nb_in;
      if (cmd.start_query) begin
         p_ff   <= qidx;
         err_ff <= !(idx_w < IW'(count_ff));
      end
      if (cmd.capture_own) begin
         own_ff  <= rd_int_ff;
         lo_ff   <= lo_val;
         hi_ff   <= hi_val;
         rank_ff <= '0;
      end else if (cmd.count_rank && (rd_int_ff > own_ff) && (rank_ff != RANK_MAX)) begin
         rank_ff <= rank_ff + RANK_W'(1);
      end
   end

   // level decision
   assign has = !err_ff && (min_ff <= max_ff) && (rank_ff <= RANK_W'(max_ff));

   always_comb begin
      rsp_data_in.status       = err_ff;
      rsp_data_in.rank         = err_ff ? '0 : rank_ff;
      rsp_data_in.has_level    = has;
      rsp_data_in.lowest_level = '0;
      if (has) begin
         rsp_data_in.lowest_level = (rank_ff > RANK_W'(min_ff)) ? rank_ff[LVL_W-1:0] : min_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sts.idx_ok   = idx_w < IW'(count_ff);
   assign sts.p_zero   = (p_ff == '0);
   assign sts.p_last   = (CW'(p_ff) + CW'(1)) >= count_ff;
   assign sts.nb_zero  = (nb_ff == '0);
   assign sts.nb_last  = (CW'(nb_ff) + CW'(1)) >= count_ff;
   assign sts.below_lo = rd_mz_ff < lo_ff;
   assign sts.above_hi = rd_mz_ff > hi_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// File: sv/windowed_peak_intensity_rank.sv
// Clear, load and op code 3 complete in ST_IDLE; req_ready stays high, so they run back to back.
// Query: the controller captures the queried peak, walks the neighbors on the left, then on the
// right (one memory read port, one entry a cycle), then loads the result and raises rsp_valid;
// an unloaded index skips the walk. The next item transfers once the result is loaded, later only
// while an earlier result still stalls. Reset (synchronous, active high) empties the spectrum,
// drops any pending result and restores window 500000, levels 2..10; peak stores are kept.
// ----------------------------------------------------------------------------
// windowed_peak_intensity_rank: top level
// Loads a spectrum's peaks and ranks a queried peak by the number of
// higher-intensity neighbors inside its m/z window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module windowed_peak_intensity_rank import wpir_pkg::*; #(
   parameter int MAX_PEAKS = WPIR_MAX_PEAKS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   // config write port
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // The controller only sequences; every store and compare lives in the datapath.
   cmd_type cmd;
   sts_type sts;

   wpir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The result register decouples the channels: a new item transfers in while
   // the last result still waits; only a second query finish waits for it.
   wpir_dpath #(
      .MAX_PEAKS (MAX_PEAKS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

// File: sv/wpir_checker.sv
// ----------------------------------------------------------------------------
// wpir_checker: port-level assertions
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpir_checker import wpir_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // error results carry no rank or level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         rsp_data.rank == '0 && rsp_data.lowest_level == '0 && !rsp_data.has_level)
      else $error("error result with nonzero fields");

   // a level implies a small rank and a level at least the rank
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.has_level |->
         rsp_data.rank[RANK_W-1:LVL_W] == '0 &&
         rsp_data.lowest_level >= rsp_data.rank[LVL_W-1:0])
      else $error("level below rank");

   // no level, level field zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_level |-> rsp_data.lowest_level == '0)
      else $error("lowest_level set without a level");

   // reset drops any pending result
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind windowed_peak_intensity_rank wpir_checker u_wpir_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
